// ===== rtl/rgb_shift_gain_gamma_correct_top_macros.svh =====
// Assertion macros for the top-level RTL file of the gamma correction block
`ifndef RGB_SHIFT_GAIN_GAMMA_CORRECT_TOP_MACROS_SVH
`define RGB_SHIFT_GAIN_GAMMA_CORRECT_TOP_MACROS_SVH

// Condition in one cycle implies a property in the next cycle
`define RSG_ASSERT_NEXT(label, clk, cond, prop) \
    label: assert property (@(posedge clk) (cond) |=> (prop)) \
        else $error("assertion failed: label");

// Condition implies a property in the same cycle, ignored during reset
`define RSG_ASSERT_NOW(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error("assertion failed: label");

`endif

// ===== rtl/rsg_pkg.sv =====
// Shared types, constants and constant functions of the gamma correction block
`timescale 1ns / 1ps

package rsg_pkg;

    localparam int CHANNEL_BITS_DEF = 8;
    localparam int FRAC_BITS        = 24;
    localparam int SHIFT_W          = 17;
    localparam int FACTOR_W         = 17;
    localparam int GAMMA_W          = 16;
    localparam int CFG_DATA_W       = 17;
    localparam int CFG_ADDR_W       = 2;
    localparam int NUM_LANES        = 3;
    // shift, gain, log setup, log squarings, gamma mult, split, exp, round
    localparam int LANE_LAT         = 6 + 2 * FRAC_BITS;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_BRIGHTNESS = 2'd0,
        REG_CONTRAST   = 2'd1,
        REG_GAMMA      = 2'd2
    } rsg_reg_idx_t;

    typedef struct packed {
        logic signed [SHIFT_W-1:0]  shift;
        logic signed [FACTOR_W-1:0] factor;
        logic        [GAMMA_W-1:0]  gamma;
    } rsg_cfg_t;

    // integer square root of a 64-bit value, bit by bit
    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = x_in;
        r = '0;
        b = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (b > x && r == 0) begin
                b = b >> 2;
            end else if (b != 0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Q1.30 value of 2^(2^-(i+1)), by repeated truncated square roots
    function automatic logic [30:0] root_q30(input int i);
        logic [63:0] t;
        t = 64'd1 << 31;
        for (int k = 0; k <= i; k++) begin
            t = isqrt64(t << 30);
        end
        return t[30:0];
    endfunction

endpackage

// ===== rtl/rsg_lane.sv =====
// One color channel: shift, gain and fixed-point power, fully pipelined
`timescale 1ns / 1ps

module rsg_lane
    import rsg_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    en,
    input  rsg_cfg_t                cfg,
    input  logic [CHANNEL_BITS-1:0] chan_in,
    output logic [CHANNEL_BITS-1:0] chan_out
);

    localparam int CB    = CHANNEL_BITS;
    localparam int EW    = (CB > 2) ? $clog2(CB) : 2;
    localparam int LOG_W = EW + FRAC_BITS;
    localparam int E_W   = LOG_W + 4;
    localparam int SW    = CB + 18;
    localparam logic [CB-1:0]  MAX_V   = {CB{1'b1}};
    localparam logic [E_W-1:0] SAT_LIM = E_W'(CB) << FRAC_BITS;

    // shift stage
    logic [CB-1:0]        s_reg;
    logic signed [SW-1:0] s_sum;
    logic signed [SW-1:0] s_div;
    logic [CB-1:0]        s_next;

    assign s_sum = $signed({10'd0, chan_in, 8'd0}) + SW'(cfg.shift);
    assign s_div = s_sum >>> 8;

    always_comb begin
        if (s_sum <= 0) begin
            s_next = '0;
        end else if (s_div > $signed({18'd0, MAX_V})) begin
            s_next = MAX_V;
        end else begin
            s_next = s_div[CB-1:0];
        end
    end

    // gain stage
    logic [CB-1:0]        p_reg;
    logic signed [SW-1:0] p_prod;
    logic signed [SW-1:0] p_div;
    logic [CB-1:0]        p_next;

    assign p_prod = $signed({17'd0, s_reg}) * SW'(cfg.factor);
    assign p_div  = p_prod >>> 8;

    always_comb begin
        if (p_prod <= 0) begin
            p_next = '0;
        end else if (p_div > $signed({18'd0, MAX_V})) begin
            p_next = MAX_V;
        end else begin
            p_next = p_div[CB-1:0];
        end
    end

    // log setup: top set bit and normalized mantissa
    logic [EW-1:0] lz_e;
    logic [30:0]   lz_x;

    always_comb begin
        lz_e = '0;
        for (int k = 0; k < CB; k++) begin
            if (p_reg[k]) begin
                lz_e = EW'(k);
            end
        end
        // place the top set bit at bit 30
        lz_x = 31'({p_reg, 31'd0} >> (1 + int'(lz_e)));
    end

    logic [30:0]          lx_reg   [0:FRAC_BITS];
    logic [LOG_W-1:0]     lg_reg   [0:FRAC_BITS];
    logic                 lzero_reg[0:FRAC_BITS];

    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg        <= s_next;
            p_reg        <= p_next;
            lx_reg[0]    <= lz_x;
            lg_reg[0]    <= {lz_e, {FRAC_BITS{1'b0}}};
            lzero_reg[0] <= (p_reg == '0);
        end
    end

    // one truncated squaring per stage yields one fraction bit
    for (genvar i = 0; i < FRAC_BITS; i++) begin : g_log
        logic [61:0] sq;
        logic [31:0] sq_t;
        assign sq   = {31'd0, lx_reg[i]} * {31'd0, lx_reg[i]};
        assign sq_t = sq[61:30];
        always_ff @(posedge aclk) begin
            if (en) begin
                lx_reg[i+1]    <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
                lg_reg[i+1]    <= lg_reg[i] | (LOG_W'(sq_t[31]) << (FRAC_BITS - 1 - i));
                lzero_reg[i+1] <= lzero_reg[i];
            end
        end
    end

    // exponent scale and split
    logic [E_W-1:0]   e_reg;
    logic             ezero_reg;
    logic [LOG_W+GAMMA_W-1:0] e_prod;

    assign e_prod = {{GAMMA_W{1'b0}}, lg_reg[FRAC_BITS]} * {{LOG_W{1'b0}}, cfg.gamma};

    logic [30:0]          acc_reg [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] f_reg   [0:FRAC_BITS];
    logic [EW-1:0]        n_reg   [0:FRAC_BITS];
    logic                 sat_reg [0:FRAC_BITS];
    logic                 zero_reg[0:FRAC_BITS];

    always_ff @(posedge aclk) begin
        if (en) begin
            e_reg       <= e_prod[E_W+11:12];
            ezero_reg   <= lzero_reg[FRAC_BITS];
            acc_reg[0]  <= 31'd1 << 30;
            f_reg[0]    <= e_reg[FRAC_BITS-1:0];
            n_reg[0]    <= e_reg[FRAC_BITS+EW-1:FRAC_BITS];
            sat_reg[0]  <= (e_reg >= SAT_LIM);
            zero_reg[0] <= ezero_reg;
        end
    end

    // one root product per stage
    for (genvar i = 0; i < FRAC_BITS; i++) begin : g_exp
        localparam logic [30:0] ROOT = root_q30(i);
        logic [61:0] prod;
        assign prod = {31'd0, acc_reg[i]} * {31'd0, ROOT};
        always_ff @(posedge aclk) begin
            if (en) begin
                acc_reg[i+1]  <= f_reg[i][FRAC_BITS-1-i] ? prod[60:30] : acc_reg[i];
                f_reg[i+1]    <= f_reg[i];
                n_reg[i+1]    <= n_reg[i];
                sat_reg[i+1]  <= sat_reg[i];
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    // round and saturate
    logic [31:0]   r_sum;
    logic [31:0]   r_val;
    logic [CB-1:0] out_next;
    logic [CB-1:0] out_reg;

    assign r_sum = {1'b0, acc_reg[FRAC_BITS]} + (32'd1 << (22 - int'(n_reg[FRAC_BITS])));
    assign r_val = r_sum >> (30 - int'(n_reg[FRAC_BITS]));

    always_comb begin
        if (zero_reg[FRAC_BITS]) begin
            out_next = (cfg.gamma == '0) ? CB'(1) : '0;
        end else if (sat_reg[FRAC_BITS] || r_val > 32'(MAX_V)) begin
            out_next = MAX_V;
        end else begin
            out_next = r_val[CB-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign chan_out = out_reg;

endmodule

// ===== rtl/rgb_shift_gain_gamma_correct_top.sv =====
// Depth: 6 + 2 x 24 pipeline stages per lane from input accept to output valid.
// Throughput: one pixel per cycle unless a held output stalls the pipeline; the
// 24-stage log squaring and 24-stage root product pipelines in each lane set the depth.
// Reset: synchronous active-low aresetn clears the valid pipeline and restores
// shift 0, gain 1.0 and gamma 1.0.
`timescale 1ns / 1ps
`include "rgb_shift_gain_gamma_correct_top_macros.svh"

module rgb_shift_gain_gamma_correct_top
    import rsg_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
    localparam int TDATA_W = ((NUM_LANES * CHANNEL_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // red_in, green_in, blue_in, zero fill
    input  logic [TDATA_W-1:0]    s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // red_out, green_out, blue_out, zero fill
    output logic [TDATA_W-1:0]    m_axis_tdata
);

    localparam int CB = CHANNEL_BITS;

    rsg_cfg_t           cfg_reg;
    logic [LANE_LAT-1:0] vld_reg;
    logic               en;

    // advance the whole pipeline unless a finished item is held
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LANE_LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.shift  <= '0;
            cfg_reg.factor <= 17'sd256;
            cfg_reg.gamma  <= 16'd4096;
            vld_reg        <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_BRIGHTNESS: cfg_reg.shift  <= $signed(cfg_wdata[SHIFT_W-1:0]);
                    REG_CONTRAST:   cfg_reg.factor <= $signed(cfg_wdata[FACTOR_W-1:0]);
                    REG_GAMMA:      cfg_reg.gamma  <= cfg_wdata[GAMMA_W-1:0];
                    default: ;
                endcase
            end
            if (en) begin
                vld_reg <= {vld_reg[LANE_LAT-2:0], s_axis_tvalid};
            end
        end
    end

    logic [NUM_LANES*CB-1:0] lanes_out;

    for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
        rsg_lane #(
            .CHANNEL_BITS(CHANNEL_BITS)
        ) u_lane (
            .aclk    (aclk),
            .en      (en),
            .cfg     (cfg_reg),
            .chan_in (s_axis_tdata[c*CB +: CB]),
            .chan_out(lanes_out[c*CB +: CB])
        );
    end

    // merge the lanes into one item
    assign m_axis_tdata = TDATA_W'(lanes_out);

    `RSG_ASSERT_NEXT(a_reset_clears_out, aclk, !aresetn, !m_axis_tvalid)
    `RSG_ASSERT_NEXT(a_stall_holds_item, aclk, aresetn && m_axis_tvalid && !m_axis_tready, !aresetn || m_axis_tvalid)
    `RSG_ASSERT_NOW(a_ready_follows_out, aclk, aresetn, m_axis_tvalid && !m_axis_tready, !s_axis_tready)

endmodule
